// ===== hw/rtl/abu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abu_pkg
// Shared types, operation codes and constants of the bitfield and bit
// manipulation unit.
// ----------------------------------------------------------------------------
package abu_pkg;

   // decode classes
   localparam logic [1:0] CLS_BITFIELD = 2'd0;
   localparam logic [1:0] CLS_EXTRACT  = 2'd1;
   localparam logic [1:0] CLS_ONESRC   = 2'd2;
   localparam logic [1:0] CLS_UNSUPP   = 2'd3;

   // bitfield operations
   localparam logic [2:0] OP_BFM_UNSIGNED = 3'd0;
   localparam logic [2:0] OP_BFM_SIGNED   = 3'd1;
   localparam logic [2:0] OP_BFM_INSERT   = 3'd2;

   // one-source operations
   localparam logic [2:0] OP_CLZ   = 3'd0;
   localparam logic [2:0] OP_CLS   = 3'd1;
   localparam logic [2:0] OP_RBIT  = 3'd2;
   localparam logic [2:0] OP_REV   = 3'd3;
   localparam logic [2:0] OP_REV32 = 3'd4;
   localparam logic [2:0] OP_REV16 = 3'd5;

   // result status
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_UNSUPP  = 2'd2;

   localparam logic [4:0]  REG_ZERO   = 5'd31;
   localparam logic [63:0] PC_STEP    = 64'd4;
   localparam logic [63:0] MASK_LO_B  = 64'h00ff00ff00ff00ff;
   localparam logic [63:0] MASK_HI_B  = 64'hff00ff00ff00ff00;
   localparam logic [6:0]  DSIZE_64   = 7'd64;
   localparam logic [6:0]  DSIZE_32   = 7'd32;

   typedef struct packed {
      logic [1:0] dclass;
      logic [2:0] op;
      logic       wide;
   } abu_ctrl_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        wr_en;
      logic [4:0]  wr_reg;
      logic [63:0] wr_value;
   } abu_result_type;

   // low w bits set, all bits for w of 64
   function automatic logic [63:0] ones(input logic [6:0] w);
      ones = w[6] ? '1 : ((64'd1 << w[5:0]) - 64'd1);
   endfunction

   function automatic logic [63:0] size_mask(input logic wide);
      size_mask = wide ? '1 : {32'h0, 32'hffff_ffff};
   endfunction

endpackage

// ===== hw/rtl/abu_bitfield.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abu_bitfield
// Bitfield move: unsigned, signed with sign extension, and insert.
// ----------------------------------------------------------------------------
module abu_bitfield (
   input  logic [2:0]  op,
   input  logic        wide,
   input  logic [63:0] src,
   input  logic [63:0] old,
   input  logic [5:0]  immr,
   input  logic [5:0]  imms,
   output logic [63:0] value,
   output logic        invalid
);

   logic [6:0]  dsize;
   logic [63:0] mask;
   logic [6:0]  width;
   logic [6:0]  lsb;
   logic [6:0]  sb;
   logic [63:0] shifted;
   logic [63:0] fmask;
   logic [63:0] field;
   logic        field_msb;

   always_comb begin
      dsize = wide ? abu_pkg::DSIZE_64 : abu_pkg::DSIZE_32;
      mask  = abu_pkg::size_mask(wide);
      if (imms >= immr) begin
         width   = {1'b0, imms} - {1'b0, immr} + 7'd1;
         lsb     = 7'd0;
         shifted = src >> immr;
      end else begin
         width   = {1'b0, imms} + 7'd1;
         lsb     = dsize - {1'b0, immr};
         shifted = src << lsb[5:0];
      end
      fmask     = abu_pkg::ones(width) << lsb[5:0];
      field     = shifted & fmask;
      sb        = lsb + width - 7'd1;
      field_msb = field[sb[5:0]];

      case (op)
         abu_pkg::OP_BFM_UNSIGNED: value = field;
         abu_pkg::OP_BFM_SIGNED: begin
            value = field_msb ? (field | (mask & ~abu_pkg::ones(sb + 7'd1))) : field;
         end
         abu_pkg::OP_BFM_INSERT: value = (old & ~fmask) | field;
         default: value = '0;
      endcase

      invalid = ({1'b0, immr} >= dsize) || ({1'b0, imms} >= dsize) ||
                !(op inside {abu_pkg::OP_BFM_UNSIGNED, abu_pkg::OP_BFM_SIGNED,
                             abu_pkg::OP_BFM_INSERT});
   end

endmodule

// ===== hw/rtl/abu_onesrc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abu_onesrc
// One-source operations: leading zero and sign counts, bit and byte reversal.
// ----------------------------------------------------------------------------
module abu_onesrc (
   input  logic [2:0]  op,
   input  logic        wide,
   input  logic [63:0] src,
   output logic [63:0] value,
   output logic        invalid,
   output logic        unsupported
);

   // leading zeros of a 64-bit word, 64 when zero
   function automatic logic [6:0] lzc64(input logic [63:0] v);
      logic [63:0] x;
      logic [6:0]  n;
      x = v;
      n = '0;
      if (v == '0) begin
         n = 7'd64;
      end else begin
         if (x[63:32] == '0) begin n[5] = 1'b1; x = x << 32; end
         if (x[63:48] == '0) begin n[4] = 1'b1; x = x << 16; end
         if (x[63:56] == '0) begin n[3] = 1'b1; x = x << 8;  end
         if (x[63:60] == '0) begin n[2] = 1'b1; x = x << 4;  end
         if (x[63:62] == '0) begin n[1] = 1'b1; x = x << 2;  end
         if (x[63] == 1'b0)  begin n[0] = 1'b1; end
      end
      return n;
   endfunction

   logic [63:0] mask;
   logic [63:0] clz_word;
   logic [63:0] cls_src;
   logic [63:0] cls_word;
   logic [6:0]  clz_cnt;
   logic [6:0]  cls_cnt;
   logic [63:0] bit_rev;
   logic [63:0] byte_rev;

   always_comb begin
      mask = abu_pkg::size_mask(wide);
      // pad a 32-bit word with ones so the count stops at 32
      clz_word = wide ? src : {src[31:0], 32'hffff_ffff};
      clz_cnt  = lzc64(clz_word);
      cls_src  = (wide ? src[63] : src[31]) ? (~src & mask) : src;
      cls_word = wide ? cls_src : {cls_src[31:0], 32'hffff_ffff};
      cls_cnt  = lzc64(cls_word) - 7'd1;

      for (int i = 0; i < 64; i++) begin
         bit_rev[i] = src[63 - i];
      end
      for (int i = 0; i < 8; i++) begin
         byte_rev[8*i +: 8] = src[8*(7 - i) +: 8];
      end

      invalid     = 1'b0;
      unsupported = 1'b0;
      case (op)
         abu_pkg::OP_CLZ:  value = {57'd0, clz_cnt};
         abu_pkg::OP_CLS:  value = {57'd0, cls_cnt};
         abu_pkg::OP_RBIT: value = wide ? bit_rev : {32'h0, bit_rev[63:32]};
         abu_pkg::OP_REV:  value = wide ? byte_rev : {32'h0, byte_rev[63:32]};
         abu_pkg::OP_REV32: begin
            value   = {byte_rev[31:0], byte_rev[63:32]};
            invalid = !wide;
         end
         abu_pkg::OP_REV16: begin
            value = ((src & abu_pkg::MASK_LO_B) << 8) | ((src & abu_pkg::MASK_HI_B) >> 8);
         end
         default: begin
            value       = '0;
            unsupported = 1'b1;
         end
      endcase
   end

endmodule

// ===== hw/rtl/abu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abu_exec
// Operand read, register pair extract, class select and write-back decision.
// ----------------------------------------------------------------------------
module abu_exec (
   input  abu_pkg::abu_ctrl_type   ctrl,
   input  logic [4:0]              dest_reg,
   input  logic [4:0]              first_reg,
   input  logic [4:0]              second_reg,
   input  logic [63:0]             first_value,
   input  logic [63:0]             second_value,
   input  logic [63:0]             dest_old_value,
   input  logic [5:0]              rotate_amount,
   input  logic [5:0]              field_top,
   input  logic [5:0]              extract_shift,
   output abu_pkg::abu_result_type result
);

   logic [63:0] mask;
   logic [6:0]  dsize;
   logic [63:0] op_a;
   logic [63:0] op_b;
   logic [63:0] op_old;
   logic [63:0] bfm_value;
   logic        bfm_invalid;
   logic [63:0] one_value;
   logic        one_invalid;
   logic        one_unsupp;
   logic [63:0] ext_value;
   logic [63:0] res;
   logic [1:0]  status;

   assign mask   = abu_pkg::size_mask(ctrl.wide);
   assign dsize  = ctrl.wide ? abu_pkg::DSIZE_64 : abu_pkg::DSIZE_32;
   // the zero register reads as zero
   assign op_a   = (first_reg == abu_pkg::REG_ZERO) ? '0 : (first_value & mask);
   assign op_b   = (second_reg == abu_pkg::REG_ZERO) ? '0 : (second_value & mask);
   assign op_old = (dest_reg == abu_pkg::REG_ZERO) ? '0 : (dest_old_value & mask);

   abu_bitfield u_bitfield (
      .op      (ctrl.op),
      .wide    (ctrl.wide),
      .src     (op_a),
      .old     (op_old),
      .immr    (rotate_amount),
      .imms    (field_top),
      .value   (bfm_value),
      .invalid (bfm_invalid)
   );

   abu_onesrc u_onesrc (
      .op          (ctrl.op),
      .wide        (ctrl.wide),
      .src         (op_a),
      .value       (one_value),
      .invalid     (one_invalid),
      .unsupported (one_unsupp)
   );

   always_comb begin
      if (extract_shift == '0) begin
         ext_value = op_b;
      end else begin
         ext_value = (op_b >> extract_shift) | (op_a << (dsize[5:0] - extract_shift));
      end

      case (ctrl.dclass)
         abu_pkg::CLS_BITFIELD: begin
            res    = bfm_value;
            status = bfm_invalid ? abu_pkg::ST_INVALID : abu_pkg::ST_DONE;
         end
         abu_pkg::CLS_EXTRACT: begin
            res    = ext_value;
            status = ({1'b0, extract_shift} >= dsize) ? abu_pkg::ST_INVALID
                                                      : abu_pkg::ST_DONE;
         end
         abu_pkg::CLS_ONESRC: begin
            res = one_value;
            if (one_unsupp) begin
               status = abu_pkg::ST_UNSUPP;
            end else if (one_invalid) begin
               status = abu_pkg::ST_INVALID;
            end else begin
               status = abu_pkg::ST_DONE;
            end
         end
         default: begin
            res    = '0;
            status = abu_pkg::ST_UNSUPP;
         end
      endcase

      result.status = status;
      result.wr_en  = (status == abu_pkg::ST_DONE) && (dest_reg != abu_pkg::REG_ZERO);
      result.wr_reg   = result.wr_en ? dest_reg : '0;
      result.wr_value = result.wr_en ? (res & mask) : '0;
   end

endmodule

// ===== hw/rtl/arm64_bitfield_and_bit_ops_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm64_bitfield_and_bit_ops_unit_top
// Executes one decoded bitfield, extract or one-source instruction per item.
// ----------------------------------------------------------------------------
// Throughput is one item per clock while the result is taken; an item is
// held in the input register, then in the result register, from which its
// result is offered. The bit operations (shifts, masks, leading-zero tree)
// sit between the two registers. The input side stalls only while both
// registers hold items and the result is not taken. The program counter
// starts at zero after reset and advances by four for every item that
// completes with status done.
module arm64_bitfield_and_bit_ops_unit_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dest_reg[4:0], first_reg[9:5], second_reg[14:10], first_value[78:15],
   // second_value[142:79], dest_old_value[206:143], rotate_amount[212:207],
   // field_top[218:213], extract_shift[224:219], zero fill[231:225]
   input  logic [231:0] req_tdata,
   // op_class[1:0], operation[4:2], wide_mode[5], zero fill[7:6]
   input  logic [7:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // write_enable[0], write_reg[5:1], write_value[69:6], next_pc[133:70],
   // zero fill[135:134]
   output logic [135:0] rsp_tdata,
   // status[1:0], zero fill[7:2]
   output logic [7:0]   rsp_tuser
);

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic [224:0]            s1_data_ff;
   logic [5:0]              s1_user_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   abu_pkg::abu_result_type rsp_result_ff;
   logic [63:0]             rsp_pc_ff;
   logic [63:0]             pc_ff;
   logic [63:0]             pc_in;
   logic                    advance;
   logic                    req_take;
   abu_pkg::abu_ctrl_type   ctrl;
   abu_pkg::abu_result_type result;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign ctrl.dclass = s1_user_ff[1:0];
   assign ctrl.op     = s1_user_ff[4:2];
   assign ctrl.wide   = s1_user_ff[5];

   abu_exec u_exec (
      .ctrl           (ctrl),
      .dest_reg       (s1_data_ff[4:0]),
      .first_reg      (s1_data_ff[9:5]),
      .second_reg     (s1_data_ff[14:10]),
      .first_value    (s1_data_ff[78:15]),
      .second_value   (s1_data_ff[142:79]),
      .dest_old_value (s1_data_ff[206:143]),
      .rotate_amount  (s1_data_ff[212:207]),
      .field_top      (s1_data_ff[218:213]),
      .extract_shift  (s1_data_ff[224:219]),
      .result         (result)
   );

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      // advance the program counter only on a completed item
      pc_in = (result.status == abu_pkg::ST_DONE) ? (pc_ff + abu_pkg::PC_STEP) : pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && s1_valid_ff) begin
            pc_ff <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_tdata[224:0];
         s1_user_ff <= req_tuser[5:0];
      end
      if (advance && s1_valid_ff) begin
         rsp_result_ff <= result;
         rsp_pc_ff     <= pc_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_pc_ff, rsp_result_ff.wr_value, rsp_result_ff.wr_reg,
                        rsp_result_ff.wr_en};
   assign rsp_tuser  = {6'd0, rsp_result_ff.status};

endmodule

// ===== hw/rtl/abu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abu_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module abu_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [7:0]   rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1:0] == abu_pkg::ST_DONE ||
                      rsp_tuser[1:0] == abu_pkg::ST_INVALID ||
                      rsp_tuser[1:0] == abu_pkg::ST_UNSUPP))
      else $error("undefined status code");

   // a write only follows a completed item and never targets the zero register
   a_write_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tuser[1:0] == abu_pkg::ST_DONE &&
                                     rsp_tdata[5:1] != abu_pkg::REG_ZERO)
      else $error("write on failed item or to zero register");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[69:1] == 69'd0)
      else $error("write fields set without write");

endmodule

bind arm64_bitfield_and_bit_ops_unit_top abu_checker u_abu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
